// ===== rtl/utf8d_pkg.sv =====
`default_nettype none

package utf8d_pkg;

    localparam int unsigned ACC_W  = 31;
    localparam int unsigned CHAR_W = 16;
    localparam int unsigned POS_W  = 16;
    localparam int unsigned LIM_W  = 16;

    localparam logic [7:0]        CONT_MASK  = 8'hc0;
    localparam logic [7:0]        CONT_TAG   = 8'h80;
    localparam logic [ACC_W-1:0]  FIRST_PRINT = 31'h20;
    localparam logic [ACC_W-1:0]  DEL_CODE    = 31'h7f;
    localparam logic [ACC_W-1:0]  PLANE1_BASE = 31'h10000;
    localparam logic [CHAR_W-1:0] SUBST_CHAR  = 16'h0024;

    localparam logic [2:0] MAX_CONT = 3'd5;

    // decoder state that does not depend on the limit width
    typedef struct packed {
        logic [2:0]       bytes_expected;
        logic             sequence_bad;
        logic [ACC_W-1:0] code_acc;
        logic             stopped;
    } t_dec_state;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              replaced;
        logic [POS_W-1:0]  out_position;
        logic              reached_limit;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/utf8d_step.sv =====
`default_nettype none

module utf8d_step
    import utf8d_pkg::*;
#(
    parameter int unsigned LIMIT_BITS = 16
) (
    input  wire t_dec_state            i_state,
    input  wire logic [LIMIT_BITS-1:0] i_count,
    input  wire logic [7:0]            i_byte,
    input  wire logic [LIM_W-1:0]      i_limit,
    output t_dec_state                 o_state,
    output logic [LIMIT_BITS-1:0]      o_count,
    output logic                       o_valid,
    output t_result                    o_result
);

    localparam int unsigned LW = (LIMIT_BITS < LIM_W) ? LIMIT_BITS : LIM_W;

    logic                  w_complete;
    logic [LIMIT_BITS-1:0] w_limit;
    logic [LIMIT_BITS:0]   w_next;
    logic                  w_full;
    logic                  w_rep;
    logic [POS_W-1:0]      w_pos;
    logic [ACC_W-1:0]      w_acc;

    always_comb begin
        o_state    = i_state;
        w_complete = 1'b0;
        if (!i_state.stopped) begin
            if (i_state.bytes_expected == 3'd0) begin
                o_state.sequence_bad = 1'b0;
                priority if (!i_byte[7]) begin
                    o_state.code_acc       = {24'd0, i_byte[6:0]};
                    o_state.bytes_expected = 3'd0;
                    w_complete             = 1'b1;
                end else if (i_byte[7:5] == 3'b110) begin
                    o_state.code_acc       = {26'd0, i_byte[4:0]};
                    o_state.bytes_expected = 3'd1;
                end else if (i_byte[7:4] == 4'b1110) begin
                    o_state.code_acc       = {27'd0, i_byte[3:0]};
                    o_state.bytes_expected = 3'd2;
                end else if (i_byte[7:3] == 5'b11110) begin
                    o_state.code_acc       = {28'd0, i_byte[2:0]};
                    o_state.bytes_expected = 3'd3;
                end else if (i_byte[7:2] == 6'b111110) begin
                    o_state.code_acc       = {29'd0, i_byte[1:0]};
                    o_state.bytes_expected = 3'd4;
                end else if (i_byte[7:1] == 7'b1111110) begin
                    o_state.code_acc       = {30'd0, i_byte[0]};
                    o_state.bytes_expected = MAX_CONT;
                end else begin
                    // stray continuation, 0xfe or 0xff: drop, keep accumulator
                    o_state.sequence_bad = 1'b1;
                end
            end else if ((i_byte & CONT_MASK) == CONT_TAG) begin
                o_state.code_acc       = {i_state.code_acc[ACC_W-7:0], i_byte[5:0]};
                o_state.bytes_expected = i_state.bytes_expected - 3'd1;
                w_complete             = (i_state.bytes_expected == 3'd1);
            end else begin
                o_state.bytes_expected = 3'd0;
                o_state.sequence_bad   = 1'b1;
            end
        end
        // limit filled: ignore the rest of the string
        if (w_complete && w_full) begin
            o_state.stopped = 1'b1;
        end
    end

    assign w_acc = o_state.code_acc;

    always_comb begin
        w_limit          = '0;
        w_limit[LW-1:0]  = i_limit[LW-1:0];
        w_pos            = '0;
        w_pos[LW-1:0]    = i_count[LW-1:0];
    end

    assign w_next = {1'b0, i_count} + {{LIMIT_BITS{1'b0}}, 1'b1};
    assign w_full = w_next >= {1'b0, w_limit};
    assign w_rep  = !((w_acc >= FIRST_PRINT) && (w_acc != DEL_CODE) && (w_acc < PLANE1_BASE));

    assign o_valid                = w_complete;
    assign o_result.char_code     = w_rep ? SUBST_CHAR : w_acc[CHAR_W-1:0];
    assign o_result.replaced      = w_rep;
    assign o_result.out_position  = w_pos;
    assign o_result.reached_limit = w_full;

    always_comb begin
        o_count = i_count;
        if (w_complete) begin
            o_count = w_next[LIMIT_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/utf8_stream_decoder_core.sv =====
// UTF-8 stream decoder.
// Slave channel: one byte per request; tdata carries in_byte and out_limit,
// tlast marks the final byte of a string. The decoder state (sequence,
// accumulator, emitted count, stop flag) returns to zero after a tlast byte.
// Master channel: one decoded character per request; tdata carries
// char_code and out_position, tuser is the replaced flag, tlast is
// reached_limit (the character that filled the output limit).
// Bytes that do not finish a character give no result.
// Throughput: one byte per cycle while s_tready is high. Results are
// registered: the decode step is a single combinational pass from the
// state registers into the result register or the skid entry.
// Stall: a result register plus one skid entry; s_tready drops only when
// both hold results, so a byte is still taken in the cycle the receiver
// first stalls. Reset (synchronous, active low) clears decoder state and
// both valid flags; nothing else is needed before the first byte.
`default_nettype none

module utf8_stream_decoder_core
    import utf8d_pkg::*;
#(
    parameter int unsigned LIMIT_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [7:0] in_byte, [23:8] out_limit
    input  wire logic        s_tlast,   // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [15:0] char_code, [31:16] out_position
    output logic             m_tuser,   // replaced
    output logic             m_tlast    // reached_limit
);

    t_dec_state            r_state, n_state, w_step_state;
    logic [LIMIT_BITS-1:0] r_count, n_count, w_step_count;
    logic                  w_step_valid;
    t_result               w_step_res;

    t_result r_out, n_out, r_skid, n_skid;
    logic    r_out_valid, n_out_valid, r_skid_valid, n_skid_valid;

    logic w_in_acc;
    logic w_out_take;

    utf8d_step #(
        .LIMIT_BITS(LIMIT_BITS)
    ) u_step (
        .i_state (r_state),
        .i_count (r_count),
        .i_byte  (s_tdata[7:0]),
        .i_limit (s_tdata[23:8]),
        .o_state (w_step_state),
        .o_count (w_step_count),
        .o_valid (w_step_valid),
        .o_result(w_step_res)
    );

    assign s_tready   = !r_skid_valid;
    assign w_in_acc   = s_tvalid && s_tready;
    assign w_out_take = r_out_valid && m_tready;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        if (w_in_acc) begin
            if (s_tlast) begin
                n_state = '0;
                n_count = '0;
            end else begin
                n_state = w_step_state;
                n_count = w_step_count;
            end
        end
    end

    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (w_out_take) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
        if (w_in_acc && w_step_valid) begin
            if (!r_out_valid || w_out_take) begin
                n_out       = w_step_res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = w_step_res;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= '0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {r_out.out_position, r_out.char_code};
    assign m_tuser  = r_out.replaced;
    assign m_tlast  = r_out.reached_limit;

    a_bad_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.sequence_bad |-> (r_state.bytes_expected == 3'd0))
        else $error("abandoned sequence still awaits continuation bytes");

    a_cont_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.bytes_expected <= MAX_CONT)
        else $error("continuation count out of range");

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a result ahead of an empty output");

    a_string_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && s_tlast) |=>
            (r_state == '0) && (r_count == '0))
        else $error("state not cleared after last byte of string");

    a_stopped_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.stopped |-> !w_step_valid)
        else $error("result produced after output limit");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import utf8d_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // [7:0] in_byte, [23:8] out_limit
    logic        s_tlast = 1'b0; // last_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // [15:0] char_code, [31:16] out_position
    logic        m_tuser;        // replaced
    logic        m_tlast;        // reached_limit

    utf8_stream_decoder_core #(.LIMIT_BITS(16)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 i_clk = ~i_clk;

    int tx_idle_pct = 30;
    int rx_idle_pct = 46;
    int mismatch_count = 0;
    int bytes_sent = 0;
    int quiet_cycles = 0;

    t_result     expected_chars[$];
    logic [7:0]  str_bytes[$];
    logic [15:0] str_limits[$];

    // decoder shadow state
    logic [2:0]  pend_cont = '0;
    logic        seq_bad = 1'b0;
    logic [30:0] code_acc = '0;
    logic [15:0] char_count = '0;
    logic        halted = 1'b0;

    function automatic bit decode_byte(input logic [7:0] b, input bit last,
                                       input logic [15:0] lim, output t_result res);
        bit          complete;
        bit          rep;
        int          n;
        logic [30:0] bits;
        logic [16:0] nxt;
        complete = 1'b0;
        res = '0;
        if (!halted) begin
            if (pend_cont == 3'd0) begin
                n = 0;
                bits = '0;
                if (b[7] == 1'b0) begin
                    n = 0; bits = 31'(b[6:0]);
                end else if (b[7:5] == 3'b110) begin
                    n = 1; bits = 31'(b[4:0]);
                end else if (b[7:4] == 4'b1110) begin
                    n = 2; bits = 31'(b[3:0]);
                end else if (b[7:3] == 5'b11110) begin
                    n = 3; bits = 31'(b[2:0]);
                end else if (b[7:2] == 6'b111110) begin
                    n = 4; bits = 31'(b[1:0]);
                end else if (b[7:1] == 7'b1111110) begin
                    n = 5; bits = 31'(b[0]);
                end else begin
                    n = -1;
                end
                if (n < 0) begin
                    seq_bad = 1'b1;
                end else begin
                    seq_bad = 1'b0;
                    code_acc = bits;
                    pend_cont = 3'(n);
                    complete = (n == 0);
                end
            end else if ((b & CONT_MASK) == CONT_TAG) begin
                code_acc = {code_acc[24:0], b[5:0]};
                pend_cont = pend_cont - 3'd1;
                complete = (pend_cont == 3'd0);
            end else begin
                // broken sequence: byte is dropped, not reused as a lead
                pend_cont = 3'd0;
                seq_bad = 1'b1;
            end

            if (complete) begin
                rep = !(code_acc >= FIRST_PRINT && code_acc != DEL_CODE &&
                        code_acc < PLANE1_BASE);
                nxt = {1'b0, char_count} + 17'd1;
                res.char_code = rep ? SUBST_CHAR : code_acc[15:0];
                res.replaced = rep;
                res.out_position = char_count;
                res.reached_limit = (nxt >= {1'b0, lim});
                char_count = nxt[15:0];
                if (res.reached_limit)
                    halted = 1'b1;
            end
        end
        if (last) begin
            pend_cont = '0;
            seq_bad = 1'b0;
            code_acc = '0;
            char_count = '0;
            halted = 1'b0;
        end
        return complete;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // sample both channels at the rising edge
    always @(posedge i_clk) begin
        t_result want;
        t_result pred;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata, '0);
                end else begin
                    want = expected_chars.pop_front();
                    if (m_tdata[15:0] !== want.char_code)
                        report_mismatch("char_code", 32'(m_tdata[15:0]),
                                        32'(want.char_code));
                    if (m_tuser !== want.replaced)
                        report_mismatch("replaced", 32'(m_tuser), 32'(want.replaced));
                    if (m_tdata[31:16] !== want.out_position)
                        report_mismatch("out_position", 32'(m_tdata[31:16]),
                                        32'(want.out_position));
                    if (m_tlast !== want.reached_limit)
                        report_mismatch("reached_limit", 32'(m_tlast),
                                        32'(want.reached_limit));
                end
            end
            if (s_tvalid && s_tready) begin
                if (decode_byte(s_tdata[7:0], s_tlast, s_tdata[23:8], pred))
                    expected_chars = {expected_chars, pred};
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("utf8_stream_decoder_core test failed");
            $finish;
        end
    end

    always @(negedge i_clk)
        m_tready <= ($urandom_range(99) >= rx_idle_pct);

    task automatic send_byte(input logic [7:0] b, input bit last, input logic [15:0] lim);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {lim, b};
        s_tlast  <= last;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic push_byte(input logic [7:0] b, input logic [15:0] lim);
        str_bytes = {str_bytes, b};
        str_limits = {str_limits, lim};
    endtask

    // send the buffered string, tlast on its final byte
    task automatic flush_string();
        int k;
        for (k = 0; k < str_bytes.size(); k++)
            send_byte(str_bytes[k], k == str_bytes.size() - 1, str_limits[k]);
        str_bytes.delete();
        str_limits.delete();
    endtask

    task automatic apply_reset();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    task automatic test_char_forms();
        push_byte(8'h1f, 16'hffff);   // control
        push_byte(8'h20, 16'hffff);   // first printable
        push_byte(8'h7f, 16'hffff);   // DEL
        push_byte(8'hc2, 16'hffff);
        push_byte(8'ha9, 16'hffff);
        push_byte(8'hef, 16'hffff);   // U+FFFF, last kept value
        push_byte(8'hbf, 16'hffff);
        push_byte(8'hbf, 16'hffff);
        push_byte(8'hf0, 16'hffff);   // U+10000, first replaced plane
        push_byte(8'h90, 16'hffff);
        push_byte(8'h80, 16'hffff);
        push_byte(8'h80, 16'hffff);
        push_byte(8'hfd, 16'hffff);   // six-byte form, accumulator all ones
        repeat (5) push_byte(8'hbf, 16'hffff);
        flush_string();
    endtask

    task automatic test_malformed();
        push_byte(8'h80, 16'hffff);   // continuation as lead
        push_byte(8'hfe, 16'hffff);
        push_byte(8'hff, 16'hffff);
        push_byte(8'hc3, 16'hffff);   // broken sequence, 'A' dropped
        push_byte(8'h41, 16'hffff);
        push_byte(8'he2, 16'hffff);   // unfinished at end of string
        flush_string();
    endtask

    task automatic test_limits();
        push_byte(8'h00, 16'h0000);   // zero limit stops at first char
        flush_string();
        push_byte(8'h61, 16'd3);
        push_byte(8'h62, 16'd1);      // lowered limit stops here
        push_byte(8'h63, 16'd1);      // ignored after stop
        flush_string();
    endtask

    task automatic build_random_string();
        int          n_chars;
        int          form;
        int          sel;
        int          cut;
        int          k;
        int          j;
        logic [15:0] lim;
        logic [31:0] r;
        logic [7:0]  b;
        sel = $urandom_range(99);
        if (sel < 5)
            lim = 16'h0000;
        else if (sel < 55)
            lim = 16'($urandom_range(1, 12));
        else if (sel < 80)
            lim = 16'($urandom_range(0, 65535));
        else
            lim = 16'hffff;
        n_chars = $urandom_range(1, 10);
        for (k = 0; k < n_chars; k++) begin
            if ($urandom_range(99) < 8)
                push_byte(8'($urandom_range(255)), lim);
            if ($urandom_range(99) < 3)
                lim = 16'($urandom_range(0, 15));
            sel = $urandom_range(99);
            form = (sel < 40) ? 1 : 2 + (sel - 40) / 12;
            cut = form;
            if ($urandom_range(99) < 4)
                cut = $urandom_range(1, form);
            r = $urandom;
            case (form)
                1: b = {1'b0, r[6:0]};
                2: b = {3'b110, r[4:0]};
                3: b = {4'b1110, r[3:0]};
                4: b = {5'b11110, r[2:0]};
                5: b = {6'b111110, r[1:0]};
                default: b = {7'b1111110, r[0]};
            endcase
            push_byte(b, lim);
            for (j = 1; j < cut; j++) begin
                r = $urandom;
                push_byte({2'b10, r[5:0]}, lim);
            end
        end
    endtask

    task automatic test_random(input int tx_pct, input int rx_pct, input int n_bytes);
        int target;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target) begin
            build_random_string();
            flush_string();
        end
    endtask

    initial begin
        apply_reset();
        test_char_forms();
        test_malformed();
        test_limits();
        test_random(30, 46, 560);
        test_random(46, 30, 560);
        test_random(0, 0, 560);
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("utf8_stream_decoder_core test passed");
        else
            $display("utf8_stream_decoder_core test failed");
        $finish;
    end

endmodule

// ===== utf8_stream_decoder_core.f =====
rtl/utf8d_pkg.sv
rtl/utf8d_step.sv
rtl/utf8_stream_decoder_core.sv
tb/testbench.sv
